[rtl/slgc_pkg.sv]
// slgc_pkg: shared constants and types of the shared letter group counter
// depends on nothing; every rtl file but slgc_ram refers to it by scoped names
`default_nettype none

package slgc_pkg;

  localparam int unsigned MAX_WORDS = 1024;
  localparam int unsigned WORD_W    = $clog2(MAX_WORDS);
  localparam int unsigned IDX_W     = $clog2(MAX_WORDS + 1);
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned LETTERS   = 26;
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned RANK_MAX  = 15;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [LETTER_W-1:0] letter_t;

  // request from the list sequencer to the union-find engine
  typedef struct packed {
    logic  init_en;    // make init_word a fresh singleton root
    word_t init_word;
    logic  join_en;    // join word_a with word_b
    word_t word_a;
    word_t word_b;
  } uf_req_t;

  typedef struct packed {
    logic busy;
    logic done;        // join finished this cycle
    logic merged;      // the join joined two distinct groups
  } uf_rsp_t;

endpackage

`default_nettype wire

[rtl/slgc_ram.sv]
// slgc_ram: generic single write port, single read port synchronous ram
// registered read data, read returns old data on a same-address write
`default_nettype none

module slgc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/slgc_letter.sv]
// slgc_letter: per-letter seen bits and last word that held each letter
// depends on slgc_pkg
`default_nettype none

module slgc_letter (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire slgc_pkg::letter_t letter_i,
  input  wire logic            upd_i,     // record word_i for letter_i
  input  wire slgc_pkg::word_t word_i,
  input  wire logic            clear_i,   // forget all letters of the list
  output logic                 in_range_o,
  output logic                 hit_o,     // letter already seen in this list
  output slgc_pkg::word_t      last_word_o
);

  logic [slgc_pkg::LETTERS-1:0] seen_q, seen_d;
  slgc_pkg::word_t              last_q [slgc_pkg::LETTERS];

  assign in_range_o  = (letter_i < slgc_pkg::LETTER_W'(slgc_pkg::LETTERS));
  assign hit_o       = in_range_o && seen_q[letter_i];
  assign last_word_o = last_q[letter_i];

  always_comb begin
    seen_d = seen_q;
    if (clear_i) begin
      seen_d = '0;
    end else if (upd_i && in_range_o) begin
      seen_d[letter_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // no reset: an entry is read only after its seen bit is set
  always_ff @(posedge clk_i) begin
    if (upd_i && in_range_o) begin
      last_q[letter_i] <= word_i;
    end
  end

endmodule

`default_nettype wire

[rtl/slgc_uf.sv]
// slgc_uf: union-find engine over parent and rank memories
// find walks with path compression, union by rank; uses slgc_pkg, slgc_ram
`default_nettype none

module slgc_uf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slgc_pkg::uf_req_t req_i,
  output slgc_pkg::uf_rsp_t      rsp_o
);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_LOAD = 5'b00010,
    U_WALK = 5'b00100,
    U_FIX  = 5'b01000,
    U_LINK = 5'b10000
  } uf_state_e;

  uf_state_e       state_q, state_d;
  logic            side_q, side_d;     // 0 while finding word a, 1 for word b
  slgc_pkg::word_t cur_q, cur_d;       // node whose entry arrives this cycle
  slgc_pkg::word_t root_q, root_d;
  slgc_pkg::rank_t rk_q, rk_d;
  slgc_pkg::word_t a_q, a_d, b_q, b_d;
  slgc_pkg::word_t ra_q, ra_d;
  slgc_pkg::rank_t rka_q, rka_d;

  slgc_pkg::word_t rd_addr;
  slgc_pkg::word_t p_rd;
  slgc_pkg::rank_t r_rd;
  logic            p_we, r_we;
  slgc_pkg::word_t p_waddr, p_wdata, r_waddr;
  slgc_pkg::rank_t r_wdata;
  logic            done, merged;

  slgc_ram #(.Width(slgc_pkg::WORD_W), .Depth(slgc_pkg::MAX_WORDS)) u_parent (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (rd_addr),
    .rdata_o (p_rd)
  );

  slgc_ram #(.Width(slgc_pkg::RANK_W), .Depth(slgc_pkg::MAX_WORDS)) u_rank (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (rd_addr),
    .rdata_o (r_rd)
  );

  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    cur_d   = cur_q;
    root_d  = root_q;
    rk_d    = rk_q;
    a_d     = a_q;
    b_d     = b_q;
    ra_d    = ra_q;
    rka_d   = rka_q;
    rd_addr = cur_q;
    p_we    = 1'b0;
    p_waddr = cur_q;
    p_wdata = root_q;
    r_we    = 1'b0;
    r_waddr = ra_q;
    r_wdata = '0;
    done    = 1'b0;
    merged  = 1'b0;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.init_en) begin
          p_we    = 1'b1;
          p_waddr = req_i.init_word;
          p_wdata = req_i.init_word;
          r_we    = 1'b1;
          r_waddr = req_i.init_word;
          r_wdata = '0;
        end
        if (req_i.join_en) begin
          a_d     = req_i.word_a;
          b_d     = req_i.word_b;
          state_d = U_LOAD;
        end
      end
      // first read in the cycle after the request, past any init write
      U_LOAD: begin
        rd_addr = a_q;
        cur_d   = a_q;
        side_d  = 1'b0;
        state_d = U_WALK;
      end
      U_WALK: begin
        if (p_rd == cur_q) begin
          root_d  = cur_q;
          rk_d    = r_rd;
          rd_addr = side_q ? b_q : a_q;
          cur_d   = side_q ? b_q : a_q;
          state_d = U_FIX;
        end else begin
          rd_addr = p_rd;
          cur_d   = p_rd;
        end
      end
      // second pass: point every node on the path straight at the root
      U_FIX: begin
        if (p_rd == root_q) begin
          if (!side_q) begin
            ra_d    = root_q;
            rka_d   = rk_q;
            side_d  = 1'b1;
            rd_addr = b_q;
            cur_d   = b_q;
            state_d = U_WALK;
          end else begin
            state_d = U_LINK;
          end
        end else begin
          p_we    = 1'b1;
          p_waddr = cur_q;
          p_wdata = root_q;
          rd_addr = p_rd;
          cur_d   = p_rd;
        end
      end
      U_LINK: begin
        done    = 1'b1;
        state_d = U_IDLE;
        if (ra_q != root_q) begin
          merged = 1'b1;
          p_we   = 1'b1;
          if (rka_q < rk_q) begin
            p_waddr = ra_q;
            p_wdata = root_q;
          end else begin
            p_waddr = root_q;
            p_wdata = ra_q;
            if ((rka_q == rk_q) && (rka_q != slgc_pkg::RANK_W'(slgc_pkg::RANK_MAX))) begin
              r_we    = 1'b1;
              r_waddr = ra_q;
              r_wdata = rka_q + slgc_pkg::RANK_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    cur_q  <= cur_d;
    root_q <= root_d;
    rk_q   <= rk_d;
    a_q    <= a_d;
    b_q    <= b_d;
    ra_q   <= ra_d;
    rka_q  <= rka_d;
  end

  assign rsp_o.busy   = (state_q != U_IDLE);
  assign rsp_o.done   = done;
  assign rsp_o.merged = merged;

endmodule

`default_nettype wire

[rtl/shared_letter_group_counter_unit.sv]
// shared_letter_group_counter_unit: counts letter-sharing word groups of a list
// a letter that joins nothing is taken at once, a list end adds an emit step
// a join walks word a to its root, fixes that path, then does so for word b
//   and links the two roots, bound by the parent memory port
// throughput: one beat per cycle while idle, joins and emits hold the input
// reset: control state and letter seen bits clear at once, memories are not cleared
`default_nettype none

module shared_letter_group_counter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic        s_axis_tuser,   // [0] word_end
  input  wire logic        s_axis_tlast,   // list_end
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [10:0] group_count, [15:11] zero
  output logic             m_axis_tuser    // [0] overflow
);

  // one-hot list sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_JOIN = 3'b010,   // waiting for the union-find engine
    ST_EMIT = 3'b100    // waiting for a free result register
  } top_state_e;

  top_state_e state_q, state_d;

  // list bookkeeping
  logic [slgc_pkg::IDX_W-1:0] wi_q, wi_d;          // index of the current word
  logic [slgc_pkg::CNT_W-1:0] cnt_q, cnt_d;        // running group count
  logic                       ovf_q, ovf_d;
  logic                       open_q, open_d;      // current word has a letter
  logic                       pend_lend_q, pend_lend_d;

  // result register
  logic                       out_valid_q, out_valid_d;
  logic [slgc_pkg::CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic                       out_ovf_q, out_ovf_d;

  slgc_pkg::letter_t letter;
  logic              accept, active, opening, close_word;
  logic              in_range, hit, letter_upd, emit_fire, clear_list;
  slgc_pkg::word_t   cur_word, last_word;
  slgc_pkg::uf_req_t uf_req;
  slgc_pkg::uf_rsp_t uf_rsp;

  assign letter        = s_axis_tdata[slgc_pkg::LETTER_W-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // words past the limit only raise overflow
  assign active     = (wi_q < slgc_pkg::IDX_W'(slgc_pkg::MAX_WORDS));
  assign opening    = !open_q;
  assign close_word = s_axis_tuser || s_axis_tlast;
  assign cur_word   = wi_q[slgc_pkg::WORD_W-1:0];
  assign letter_upd = accept && active && in_range;

  assign emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign clear_list = emit_fire;

  slgc_letter u_letter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .letter_i    (letter),
    .upd_i       (letter_upd),
    .word_i      (cur_word),
    .clear_i     (clear_list),
    .in_range_o  (in_range),
    .hit_o       (hit),
    .last_word_o (last_word)
  );

  // the engine writes the fresh root in the accept cycle and starts its
  // walk in the following cycle, so a join on a word's first letter sees it
  assign uf_req.init_en   = accept && opening && active;
  assign uf_req.init_word = cur_word;
  assign uf_req.join_en   = accept && active && hit;
  assign uf_req.word_a    = cur_word;
  assign uf_req.word_b    = last_word;

  slgc_uf u_uf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (uf_req),
    .rsp_o  (uf_rsp)
  );

  always_comb begin
    state_d     = state_q;
    wi_d        = wi_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    open_d      = open_q;
    pend_lend_d = pend_lend_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_cnt_d   = out_cnt_q;
    out_ovf_d   = out_ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (uf_req.init_en) begin
            cnt_d = cnt_q + slgc_pkg::CNT_W'(1);
          end
          if (opening && !active) begin
            ovf_d = 1'b1;
          end
          open_d = !close_word;
          if (close_word && active) begin
            wi_d = wi_q + slgc_pkg::IDX_W'(1);
          end
          pend_lend_d = s_axis_tlast;
          if (uf_req.join_en) begin
            state_d = ST_JOIN;
          end else if (s_axis_tlast) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_JOIN: begin
        if (uf_rsp.done) begin
          if (uf_rsp.merged && (cnt_q != '0)) begin
            cnt_d = cnt_q - slgc_pkg::CNT_W'(1);
          end
          state_d = pend_lend_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_q;
          out_ovf_d   = ovf_q;
          wi_d        = '0;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          open_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wi_q        <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      open_q      <= 1'b0;
      pend_lend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wi_q        <= wi_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      open_q      <= open_d;
      pend_lend_q <= pend_lend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cnt_q <= out_cnt_d;
    out_ovf_q <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - slgc_pkg::CNT_W){1'b0}}, out_cnt_q};
  assign m_axis_tuser  = out_ovf_q;

  // a beat is only taken while the engine is idle
  a_accept_engine_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !uf_rsp.busy)
    else $error("input beat accepted while union-find engine busy");

  // groups never outnumber the words opened so far
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} <= ({1'b0, wi_q} + {{slgc_pkg::IDX_W{1'b0}}, open_q})))
    else $error("group count exceeds number of words");

  // a result beat appears only from the emit step
  a_emit_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("result beat without list end");

  // the engine reports a merge only when it finishes
  a_merge_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    uf_rsp.merged |-> (uf_rsp.done && (state_q == ST_JOIN)))
    else $error("merge reported outside a join");

endmodule

`default_nettype wire

[verif/shared_letter_group_counter_checker.sv]
// shared_letter_group_counter_checker: watches both streams of the group counter,
// tracks word groups with its own union-find copy and compares every result beat
// depends on slgc_pkg for sizes and types
`timescale 1ns / 100ps

module shared_letter_group_counter_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] in_data_i,    // [4:0] letter, [7:5] zero
  input  wire logic       in_user_i,    // [0] word_end
  input  wire logic       in_last_i,    // list_end
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [15:0] out_data_i,  // [10:0] group_count, [15:11] zero
  input  wire logic       out_user_i,   // [0] overflow
  output int              mismatch_count_o,
  output int              pending_o
);

  typedef struct packed {
    logic [slgc_pkg::CNT_W-1:0] count;
    logic                       overflow;
  } group_beat_t;

  // union-find copy over word indices
  slgc_pkg::word_t              parent_mem [slgc_pkg::MAX_WORDS];
  slgc_pkg::rank_t              rank_mem   [slgc_pkg::MAX_WORDS];
  slgc_pkg::word_t              last_holder [slgc_pkg::LETTERS];
  logic [slgc_pkg::LETTERS-1:0] seen_mask;
  logic [slgc_pkg::IDX_W-1:0]   word_cnt;
  logic [slgc_pkg::CNT_W-1:0]   groups;
  logic                         ovf;
  logic                         in_word;

  group_beat_t expected_counts[$];

  function automatic void clear_list();
    seen_mask = '0;
    word_cnt  = '0;
    groups    = '0;
    ovf       = 1'b0;
    in_word   = 1'b0;
  endfunction

  function automatic slgc_pkg::word_t root_of_word(input slgc_pkg::word_t w);
    slgc_pkg::word_t root;
    slgc_pkg::word_t nxt;
    int              steps;
    root  = w;
    steps = 0;
    while (parent_mem[root] != root && steps < slgc_pkg::MAX_WORDS) begin
      root = parent_mem[root];
      steps++;
    end
    while (parent_mem[w] != root) begin
      nxt           = parent_mem[w];
      parent_mem[w] = root;
      w             = nxt;
    end
    return root;
  endfunction

  function automatic void merge_groups(input slgc_pkg::word_t a, input slgc_pkg::word_t b);
    slgc_pkg::word_t ra;
    slgc_pkg::word_t rb;
    ra = root_of_word(a);
    rb = root_of_word(b);
    if (ra == rb) return;
    if (rank_mem[ra] < rank_mem[rb]) begin
      parent_mem[ra] = rb;
    end else if (rank_mem[ra] > rank_mem[rb]) begin
      parent_mem[rb] = ra;
    end else begin
      parent_mem[rb] = ra;
      if (rank_mem[ra] != slgc_pkg::rank_t'(slgc_pkg::RANK_MAX)) rank_mem[ra]++;
    end
    if (groups != 0) groups--;
  endfunction

  // returns 1 when the letter closes the list, with the count in beat
  function automatic bit predict_letter(input slgc_pkg::letter_t ltr, input logic wend,
                                        input logic lend, output group_beat_t beat);
    bit              active;
    slgc_pkg::word_t cur;
    active = (word_cnt < slgc_pkg::MAX_WORDS);
    cur    = slgc_pkg::word_t'(word_cnt);
    if (!in_word) begin
      in_word = 1'b1;
      if (active) begin
        parent_mem[cur] = cur;
        rank_mem[cur]   = '0;
        groups++;
      end else begin
        ovf = 1'b1;
      end
    end
    if (active && ltr < slgc_pkg::LETTERS) begin
      if (seen_mask[ltr]) merge_groups(cur, last_holder[ltr]);
      seen_mask[ltr]   = 1'b1;
      last_holder[ltr] = cur;
    end
    if (wend || lend) begin
      in_word = 1'b0;
      if (word_cnt < slgc_pkg::MAX_WORDS) word_cnt++;
    end
    beat.count    = groups;
    beat.overflow = ovf;
    if (lend) begin
      clear_list();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    group_beat_t want;
    if (!rst_ni) begin
      clear_list();
      expected_counts.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_counts.size() == 0) begin
          $error("result beat with no list pending: group_count %0d overflow %0d",
                 out_data_i[10:0], out_user_i);
          mismatch_count_o++;
        end else begin
          want = expected_counts.pop_front();
          if (out_data_i[10:0] !== want.count) begin
            $error("group_count mismatch: expected %0d, actual %0d",
                   want.count, out_data_i[10:0]);
            mismatch_count_o++;
          end
          if (out_user_i !== want.overflow) begin
            $error("overflow mismatch: expected %0d, actual %0d", want.overflow, out_user_i);
            mismatch_count_o++;
          end
          if (out_data_i[15:11] !== 5'd0) begin
            $error("tdata padding mismatch: expected 0, actual %0d", out_data_i[15:11]);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (predict_letter(slgc_pkg::letter_t'(in_data_i[4:0]), in_user_i, in_last_i, want))
          expected_counts.push_back(want);
      end
      pending_o = expected_counts.size();
    end
  end

endmodule

[verif/shared_letter_group_counter_unit_test.sv]
// shared_letter_group_counter_unit_test: drives letter lists into the group counter,
// throttles the result side and gives the verdict
// depends on slgc_pkg, shared_letter_group_counter_unit and shared_letter_group_counter_checker
`timescale 1ns / 100ps

module shared_letter_group_counter_unit_test;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [4:0] letter, [7:5] zero
  logic        s_axis_tuser;   // [0] word_end
  logic        s_axis_tlast;   // list_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [10:0] group_count, [15:11] zero
  logic        m_axis_tuser;   // [0] overflow

  int mismatches;
  int pending;

  // knobs for the sender and the receiver
  bit calm      = 1'b0;  // no idling on either side
  int idle_rate = 0;     // sender gap odds in eighths, 0 means none
  bit hold_req  = 1'b0;  // toggled by the sender to start a long hold-off
  int items_sent = 0;

  shared_letter_group_counter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  shared_letter_group_counter_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .in_last_i        (s_axis_tlast),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_user_i       (m_axis_tuser),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall bursts, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    int stall_rate;
    int hold_left;
    bit hold_seen;
    stall_left    = 0;
    stall_rate    = 2;
    hold_left     = 0;
    hold_seen     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      // switch the stall odds now and then, 0 gives runs without stalls
      if ($urandom_range(0, 63) == 0) stall_rate = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
        stall_left = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one letter beat, called at a falling edge and returning at one
  task automatic send_letter(input slgc_pkg::letter_t ltr, input logic wend,
                             input logic lend);
    int gap;
    gap = 0;
    if (!calm && idle_rate != 0 && $urandom_range(0, 7) < idle_rate)
      gap = $urandom_range(1, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, ltr};
    s_axis_tuser  <= wend;
    s_axis_tlast  <= lend;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // a list over a random window of the alphabet, with a few out-of-range letters;
  // a narrow window forces many joins, a wide one keeps groups apart
  task automatic random_list(input int max_words, input int max_len);
    int                n_words;
    int                len;
    int                base;
    int                span;
    slgc_pkg::letter_t ltr;
    logic              wend;
    logic              lend;
    n_words   = $urandom_range(1, max_words);
    span      = $urandom_range(1, 26);
    base      = $urandom_range(0, 26 - span);
    idle_rate = $urandom_range(0, 3);
    for (int w = 0; w < n_words; w++) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) ltr = slgc_pkg::letter_t'($urandom_range(26, 31));
        else ltr = slgc_pkg::letter_t'(base + $urandom_range(0, span - 1));
        lend = (w == n_words - 1) && (i == len - 1);
        // the list end sometimes closes the last word on its own
        wend = (i == len - 1) && !(lend && $urandom_range(0, 3) == 0);
        send_letter(ltr, wend, lend);
      end
    end
  endtask

  // a list of n_words single-letter words; far_only keeps every letter
  // out of range so that no word joins another
  task automatic flood_list(input int n_words, input bit far_only);
    slgc_pkg::letter_t ltr;
    idle_rate = $urandom_range(0, 1);
    for (int w = 0; w < n_words; w++) begin
      ltr = far_only ? slgc_pkg::letter_t'($urandom_range(26, 31))
                     : slgc_pkg::letter_t'($urandom_range(0, 31));
      send_letter(ltr, 1'b1, w == n_words - 1);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed lists
    idle_rate = 0;
    send_letter(5'd0, 1'b1, 1'b1);    // "a" alone, one group
    send_letter(5'd25, 1'b0, 1'b1);   // "z" closed by the list end only
    send_letter(5'd0, 1'b0, 1'b0);    // "ab" "bc" "d": two groups
    send_letter(5'd1, 1'b1, 1'b0);
    send_letter(5'd1, 1'b0, 1'b0);
    send_letter(5'd2, 1'b1, 1'b0);
    send_letter(5'd3, 1'b1, 1'b1);
    send_letter(5'd0, 1'b0, 1'b0);    // "aa" "b": repeated letter joins the word to itself
    send_letter(5'd0, 1'b1, 1'b0);
    send_letter(5'd1, 1'b1, 1'b1);
    send_letter(5'd31, 1'b1, 1'b0);   // out-of-range letters still make words
    send_letter(5'd26, 1'b1, 1'b0);
    send_letter(5'd31, 1'b0, 1'b0);
    send_letter(5'd0, 1'b1, 1'b1);
    send_letter(5'd0, 1'b0, 1'b0);    // "ab" "cd" "bc": chain into one group
    send_letter(5'd1, 1'b1, 1'b0);
    send_letter(5'd2, 1'b0, 1'b0);
    send_letter(5'd3, 1'b1, 1'b0);
    send_letter(5'd1, 1'b0, 1'b0);
    send_letter(5'd2, 1'b1, 1'b1);

    // random lists with idling on both sides
    while (items_sent < 300) random_list(8, 5);

    // long receiver hold-off while short lists keep coming, the block must backpressure
    idle_rate = 0;
    hold_req  = ~hold_req;
    repeat (40) send_letter(slgc_pkg::letter_t'($urandom_range(0, 31)), 1'b1, 1'b1);

    // sender pause until the last result is out
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);

    // a long list of words that never join gives a large count,
    // then a long list whose letters collide often
    flood_list(100, 1'b1);
    flood_list(100, 1'b0);

    // some longer lists and words, then a quiet tail without idling
    while (items_sent < 780) random_list(30, 8);
    calm = 1'b1;
    do random_list(8, 5); while (items_sent < 950);

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    // room for a stray extra result beat
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/slgc_pkg.sv
rtl/slgc_ram.sv
rtl/slgc_letter.sv
rtl/slgc_uf.sv
rtl/shared_letter_group_counter_unit.sv
verif/shared_letter_group_counter_checker.sv
verif/shared_letter_group_counter_unit_test.sv
